### hw/rtl/gra_pkg.sv
// gra_pkg: shared types and constants of the gaussian repulsion block
// depends on nothing; used by every rtl file of the block
package gra_pkg;

  // request payload of the input channel
  typedef struct packed {
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic signed [31:0] own_z;
    logic        [30:0] own_radius;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic               last_source;
  } in_req_t;

  // request payload of the result channel
  typedef struct packed {
    logic signed [31:0] delta_vx;
    logic signed [31:0] delta_vy;
    logic signed [31:0] delta_vz;
  } out_req_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_FACTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_GAIN  = 1'b1;

  // digit-serial multiplier: 33 x 33 unsigned, 4-bit digits
  localparam int unsigned MUL_W     = 33;
  localparam int unsigned DIG_W     = 4;
  localparam int unsigned MUL_STEPS = (MUL_W + DIG_W - 1) / DIG_W;
  localparam int unsigned MUL_BW    = MUL_STEPS * DIG_W;
  localparam int unsigned PROD_W    = 2 * MUL_W;

  // bit-serial divider: 4 integer and 17 fraction quotient bits
  localparam int unsigned DIV_INT_BITS  = 4;
  localparam int unsigned DIV_FRAC_BITS = 17;
  localparam int unsigned DIV_STEPS     = DIV_INT_BITS + DIV_FRAC_BITS;
  localparam int unsigned NUM_W         = 64;
  localparam int unsigned DEN_W         = 62;

  // handshake between sequencer and an arithmetic unit
  typedef struct packed {
    logic start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_cmd_t;

endpackage

### hw/rtl/gaussian_repulsion_accumulate_top.sv
// each request runs the squares, the divide, the exponent squarings and the force
// products in turn; a far pair or zero radius ends after the radius square
// one request at a time: in_stall stays high until it is done; the single 4-bit
// digit-serial multiplier does every product, the quotient comes one bit a cycle
// reset (rst_n low, synchronous): sums cleared, force_factor and energy_gain 1.0
module gaussian_repulsion_accumulate_top #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gra_pkg::in_req_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gra_pkg::out_req_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);

  localparam int unsigned ECW   = $clog2(EXP_TABLE_BITS + 1);
  localparam int unsigned XSH   = 15 - EXP_TABLE_BITS;
  localparam int unsigned QW    = gra_pkg::DIV_STEPS;
  localparam int unsigned PW    = gra_pkg::PROD_W;
  // quotient at or above this means the exp base is zero or negative
  localparam logic [32:0] T_LIM = 33'(1) << (16 + EXP_TABLE_BITS);

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  // product currently running in the multiplier
  typedef enum logic [3:0] {
    OP_SQX, OP_SQY, OP_SQZ, OP_SQR, OP_EXP, OP_GAIN, OP_FACT, OP_CX, OP_CY, OP_CZ
  } op_t;

  state_t                   state_r;
  op_t                      op_r;
  logic                     issue_r;
  logic [ECW-1:0]           exp_cnt_r;

  // configuration
  logic signed [31:0]       factor_r;
  logic        [30:0]       gain_r;

  // per-request working registers
  logic signed [32:0]       rx_r, ry_r, rz_r;
  logic        [30:0]       radius_r;
  logic                     last_r;
  logic        [63:0]       d_r;
  logic        [61:0]       s2_r;
  logic        [31:0]       b_r;
  logic        [30:0]       en_r;
  logic signed [31:0]       fe_r;

  // running sums, units of 2^-16
  logic signed [47:0]       sum_x_r, sum_y_r, sum_z_r;

  logic                     out_valid_r;
  gra_pkg::out_req_t        out_data_r;

  gra_pkg::mul_cmd_t        mul_cmd;
  logic                     mul_done;
  logic [PW-1:0]            mul_p;
  logic                     div_done;
  logic [QW-1:0]            div_q;

  logic                     in_take;
  logic                     out_free;
  logic                     far;
  logic                     exp_zero;
  logic [32:0]              xsh;
  logic                     p_neg;
  logic signed [51:0]       p_floor;
  logic signed [31:0]       fe_val;
  logic signed [47:0]       sum_sel;
  logic signed [47:0]       sum_val;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [52:0] v);
    if (v > 53'sh0_7FFF_FFFF_FFFF) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < -53'sh0_8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end
    return 48'(v);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [51:0] v);
    if (v > 52'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -52'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // operand select for the shared multiplier
  always_comb begin
    mul_cmd.start = issue_r && (state_r == ST_MUL);
    mul_cmd.a     = '0;
    mul_cmd.b     = '0;
    case (op_r)
      OP_SQX: begin
        mul_cmd.a = mag33(rx_r);
        mul_cmd.b = mag33(rx_r);
      end
      OP_SQY: begin
        mul_cmd.a = mag33(ry_r);
        mul_cmd.b = mag33(ry_r);
      end
      OP_SQZ: begin
        mul_cmd.a = mag33(rz_r);
        mul_cmd.b = mag33(rz_r);
      end
      OP_SQR: begin
        mul_cmd.a = 33'(radius_r);
        mul_cmd.b = 33'(radius_r);
      end
      OP_EXP: begin
        mul_cmd.a = 33'(b_r);
        mul_cmd.b = 33'(b_r);
      end
      OP_GAIN: begin
        mul_cmd.a = 33'(gain_r);
        mul_cmd.b = 33'(b_r);
      end
      OP_FACT: begin
        mul_cmd.a = mag33(33'(factor_r));
        mul_cmd.b = 33'(en_r);
      end
      OP_CX: begin
        mul_cmd.a = mag33(33'(fe_r));
        mul_cmd.b = mag33(rx_r);
      end
      OP_CY: begin
        mul_cmd.a = mag33(33'(fe_r));
        mul_cmd.b = mag33(ry_r);
      end
      OP_CZ: begin
        mul_cmd.a = mag33(33'(fe_r));
        mul_cmd.b = mag33(rz_r);
      end
      default: begin
        mul_cmd.a = '0;
        mul_cmd.b = '0;
      end
    endcase
  end

  gra_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mul_cmd),
    .done  (mul_done),
    .prod  (mul_p)
  );

  gra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (issue_r && (state_r == ST_DIV)),
    .num   (d_r),
    .den   (s2_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // pair out of reach: d/16 at or above sigma squared (covers zero radius)
  assign far      = {2'b0, d_r[63:4]} >= mul_p[61:0];
  assign exp_zero = 33'(div_q) >= T_LIM;
  assign xsh      = 33'(div_q) << XSH;

  // signed product shifted down 16 with floor toward minus infinity
  always_comb begin
    case (op_r)
      OP_FACT: p_neg = factor_r[31];
      OP_CX:   p_neg = fe_r[31] ^ rx_r[32];
      OP_CY:   p_neg = fe_r[31] ^ ry_r[32];
      OP_CZ:   p_neg = fe_r[31] ^ rz_r[32];
      default: p_neg = 1'b0;
    endcase
  end

  always_comb begin
    logic [50:0] m;
    m = 51'(mul_p[PW-1:16]) + 51'(p_neg && (mul_p[15:0] != '0));
    p_floor = p_neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  end

  assign fe_val = clamp32(p_floor);

  always_comb begin
    case (op_r)
      OP_CX:   sum_sel = sum_x_r;
      OP_CY:   sum_sel = sum_y_r;
      OP_CZ:   sum_sel = sum_z_r;
      default: sum_sel = sum_x_r;
    endcase
  end

  assign sum_val = clamp48(53'(sum_sel) + 53'(p_floor));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= 32'sh0001_0000;
      gain_r   <= 31'h0001_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gra_pkg::CFG_FORCE_FACTOR: factor_r <= cfg_data;
        gra_pkg::CFG_ENERGY_GAIN:  gain_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_SQX;
      issue_r     <= 1'b0;
      exp_cnt_r   <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      issue_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            state_r <= ST_MUL;
            op_r    <= OP_SQX;
            issue_r <= 1'b1;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            issue_r <= 1'b1;
            case (op_r)
              OP_SQX: op_r <= OP_SQY;
              OP_SQY: op_r <= OP_SQZ;
              OP_SQZ: op_r <= OP_SQR;
              OP_SQR: begin
                state_r <= far ? ST_FIN : ST_DIV;
                issue_r <= !far;
              end
              OP_EXP: begin
                exp_cnt_r <= exp_cnt_r - ECW'(1);
                if (exp_cnt_r == ECW'(1)) begin
                  op_r <= OP_GAIN;
                end
              end
              OP_GAIN: op_r <= OP_FACT;
              OP_FACT: op_r <= OP_CX;
              OP_CX: begin
                sum_x_r <= sum_val;
                op_r    <= OP_CY;
              end
              OP_CY: begin
                sum_y_r <= sum_val;
                op_r    <= OP_CZ;
              end
              OP_CZ: begin
                sum_z_r <= sum_val;
                state_r <= ST_FIN;
                issue_r <= 1'b0;
              end
              default: state_r <= ST_FIN;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (exp_zero) begin
              state_r <= ST_FIN;
            end else begin
              state_r   <= ST_MUL;
              op_r      <= OP_EXP;
              exp_cnt_r <= ECW'(EXP_TABLE_BITS);
              issue_r   <= 1'b1;
            end
          end
        end
        ST_FIN: begin
          // last source: hand out the saturated sums once the output is free; else back to idle
          if (!last_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_valid_r <= 1'b1;
            sum_x_r     <= '0;
            sum_y_r     <= '0;
            sum_z_r     <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // working data path
  always_ff @(posedge clk) begin
    if (in_take) begin
      rx_r     <= 33'(in_data.own_x) - 33'(in_data.source_x);
      ry_r     <= 33'(in_data.own_y) - 33'(in_data.source_y);
      rz_r     <= 33'(in_data.own_z) - 33'(in_data.source_z);
      radius_r <= in_data.own_radius;
      last_r   <= in_data.last_source;
      d_r      <= '0;
    end
    if (state_r == ST_MUL && mul_done) begin
      case (op_r)
        OP_SQX, OP_SQY, OP_SQZ: d_r <= d_r + mul_p[PW-1:2];
        OP_SQR:  s2_r <= mul_p[61:0];
        OP_EXP:  b_r  <= mul_p[62:31];
        OP_GAIN: en_r <= mul_p[61:31];
        OP_FACT: fe_r <= fe_val;
        default: ;
      endcase
    end
    if (state_r == ST_DIV && div_done) begin
      b_r <= 32'h8000_0000 - xsh[31:0];
    end
    if (state_r == ST_FIN && last_r && out_free) begin
      out_data_r.delta_vx <= clamp32(52'(sum_x_r));
      out_data_r.delta_vy <= clamp32(52'(sum_y_r));
      out_data_r.delta_vz <= clamp32(52'(sum_z_r));
    end
  end

endmodule

### hw/rtl/gra_mul.sv
// gra_mul: unsigned multiplier, one 4-bit digit of b per cycle
// depends on gra_pkg
module gra_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gra_pkg::mul_cmd_t            cmd,
  output logic                         done,
  output logic [gra_pkg::PROD_W-1:0]   prod
);

  localparam int unsigned CW = $clog2(gra_pkg::MUL_STEPS + 1);
  localparam int unsigned SW = gra_pkg::MUL_W + gra_pkg::DIG_W;

  logic [gra_pkg::MUL_W-1:0]  a_r;
  logic [gra_pkg::MUL_W-1:0]  hi_r;
  logic [gra_pkg::MUL_BW-1:0] lo_r;
  logic [CW-1:0]              cnt_r;
  logic                       done_r;
  logic [SW-1:0]              sum;

  assign sum  = SW'(hi_r) + SW'(a_r) * SW'(lo_r[gra_pkg::DIG_W-1:0]);
  assign done = done_r;
  assign prod = gra_pkg::PROD_W'({hi_r, lo_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        cnt_r <= CW'(gra_pkg::MUL_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-add datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r  <= cmd.a;
      hi_r <= '0;
      lo_r <= gra_pkg::MUL_BW'(cmd.b);
    end else if (cnt_r != '0) begin
      hi_r <= sum[SW-1:gra_pkg::DIG_W];
      lo_r <= {sum[gra_pkg::DIG_W-1:0], lo_r[gra_pkg::MUL_BW-1:gra_pkg::DIG_W]};
    end
  end

endmodule

### hw/rtl/gra_div.sv
// gra_div: restoring divider, one quotient bit per cycle
// depends on gra_pkg; numerator must satisfy num / 16 < den
module gra_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gra_pkg::NUM_W-1:0]     num,
  input  logic [gra_pkg::DEN_W-1:0]     den,
  output logic                          done,
  output logic [gra_pkg::DIV_STEPS-1:0] quo
);

  localparam int unsigned CW = $clog2(gra_pkg::DIV_STEPS + 1);
  localparam int unsigned QS = gra_pkg::DIV_STEPS;
  localparam int unsigned IB = gra_pkg::DIV_INT_BITS;

  logic [gra_pkg::DEN_W-1:0] den_r;
  logic [gra_pkg::DEN_W-1:0] rem_r;
  logic [QS-1:0]             feed_r;
  logic [QS-1:0]             q_r;
  logic [CW-1:0]             cnt_r;
  logic                      done_r;
  logic [gra_pkg::DEN_W:0]   trial;
  logic                      ge;

  assign trial = {rem_r, feed_r[QS-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quo   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(QS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r  <= den;
      rem_r  <= gra_pkg::DEN_W'(num[gra_pkg::NUM_W-1:IB]);
      feed_r <= {num[IB-1:0], (QS-IB)'(0)};
      q_r    <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= ge ? gra_pkg::DEN_W'(trial - {1'b0, den_r}) : trial[gra_pkg::DEN_W-1:0];
      feed_r <= {feed_r[QS-2:0], 1'b0};
      q_r    <= {q_r[QS-2:0], ge};
    end
  end

endmodule

### hw/rtl/gra_chk.sv
// gra_chk: port-level checks of the gaussian repulsion block, bound to the top
// depends on gra_pkg and gaussian_repulsion_accumulate_top
module gra_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input gra_pkg::out_req_t             out_data
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request at a time: busy right after taking one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind gaussian_repulsion_accumulate_top gra_chk u_gra_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### dv/gra_checker.sv
// gra_checker: watches the request, result and register channels of the block,
// predicts each velocity increment and compares it; depends on gra_pkg
`timescale 1ns / 100ps
module gra_checker #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  gra_pkg::in_req_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  gra_pkg::out_req_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [gra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            result_count
);
  import gra_pkg::*;

  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam longint W_MAX   = 64'sh7FFF_FFFF;
  localparam longint W_MIN   = -64'sh8000_0000;

  longint     factor_q;
  longint     gain_q;
  longint     acc_x, acc_y, acc_z;
  out_req_t   increment_q[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // factor * alpha * exp(-d2 / (2 sigma^2)), Q16.16, saturated to 32 bits
  function automatic longint pair_weight(longint unsigned d, longint unsigned rad);
    logic [127:0]    s2, q, x;
    longint unsigned b, en;
    if (rad == 0) return 0;
    s2 = 128'(rad) * 128'(rad);
    if (128'(d >> 4) >= s2) return 0;
    q = (128'(d) << 17) / s2;
    x = q << (15 - EXP_TABLE_BITS);
    if (x >= (128'd1 << 31)) begin
      b = 0;
    end else begin
      b = 64'(( 128'd1 << 31) - x);
      for (int i = 0; i < EXP_TABLE_BITS; i++) b = (b * b) >> 31;
    end
    en = (longint'(gain_q) * b) >> 31;
    return clip((factor_q * longint'(en)) >>> 16, W_MIN, W_MAX);
  endfunction

  task automatic absorb_pair(in_req_t it);
    longint          rx, ry, rz, fe;
    longint unsigned ax, ay, az, d;
    out_req_t        o;
    rx = longint'(it.own_x) - longint'(it.source_x);
    ry = longint'(it.own_y) - longint'(it.source_y);
    rz = longint'(it.own_z) - longint'(it.source_z);
    ax = rx < 0 ? -rx : rx;
    ay = ry < 0 ? -ry : ry;
    az = rz < 0 ? -rz : rz;
    d  = ((ax * ax) >> 2) + ((ay * ay) >> 2) + ((az * az) >> 2);
    fe = pair_weight(d, longint'(it.own_radius));
    acc_x = clip(acc_x + ((fe * rx) >>> 16), SUM_MIN, SUM_MAX);
    acc_y = clip(acc_y + ((fe * ry) >>> 16), SUM_MIN, SUM_MAX);
    acc_z = clip(acc_z + ((fe * rz) >>> 16), SUM_MIN, SUM_MAX);
    if (it.last_source) begin
      o.delta_vx = 32'(clip(acc_x, W_MIN, W_MAX));
      o.delta_vy = 32'(clip(acc_y, W_MIN, W_MAX));
      o.delta_vz = 32'(clip(acc_z, W_MIN, W_MAX));
      increment_q.push_back(o);
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
    end
  endtask

  assign pending = increment_q.size();

  always @(posedge clk) begin
    out_req_t e;
    if (!rst_n) begin
      factor_q = 65536;
      gain_q   = 65536;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      increment_q.delete();
      fail_count   <= 0;
      result_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FORCE_FACTOR) factor_q = longint'($signed(cfg_data));
        else if (cfg_index == CFG_ENERGY_GAIN) gain_q = longint'(cfg_data[30:0]);
      end
      if (in_valid && !in_stall) absorb_pair(in_data);
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (increment_q.size() == 0) begin
          $display("%0t: unexpected increment, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = increment_q.pop_front();
          if (e.delta_vx !== out_data.delta_vx || e.delta_vy !== out_data.delta_vy ||
              e.delta_vz !== out_data.delta_vz) begin
            $display("%0t: increment mismatch, expected %0d %0d %0d, actual %0d %0d %0d",
                     $time, e.delta_vx, e.delta_vy, e.delta_vz,
                     out_data.delta_vx, out_data.delta_vy, out_data.delta_vz);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### dv/tb.sv
// tb: stimulus and verdict for gaussian_repulsion_accumulate_top
// depends on gra_pkg, the block, and gra_checker for prediction and compare
`timescale 1ns / 100ps
module tb;
  import gra_pkg::*;

  localparam int LIMIT    = 3000000;  // cycles, several times the slowest run
  localparam int SETTLE   = 300;      // cycles, longer than one request takes
  localparam int N_RANDOM = 900;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 0;
  out_req_t out_data;
  logic     cfg_valid = 0;
  logic     cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FORCE_FACTOR;
  logic [31:0] cfg_data = '0;

  int fail_count, pending, result_count;
  int cycles = 0;
  int sent = 0;

  // clock, 8 ns period
  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  gaussian_repulsion_accumulate_top u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  gra_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .result_count
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("gaussian_repulsion_accumulate_top regression: fail");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // receiver backpressure: random runs of stall and no stall
  always @(posedge clk) begin
    static int run = 0;
    static bit calm = 0;
    if (run == 0) begin
      calm = ($urandom_range(0, 9) == 0);
      run = $urandom_range(1, 60);
      out_stall <= calm ? 1'b0 : (gap_len() > 0);
    end else begin
      run--;
    end
  end

  task automatic send_request(in_req_t it);
    int g;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // only between phases: results drained and the block quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_req_t pair(logic signed [31:0] ox, oy, oz, logic [30:0] rad,
                                   logic signed [31:0] sx, sy, sz, logic last);
    in_req_t it;
    it.own_x = ox; it.own_y = oy; it.own_z = oz; it.own_radius = rad;
    it.source_x = sx; it.source_y = sy; it.source_z = sz; it.last_source = last;
    return it;
  endfunction

  // offset within a few radii so the gaussian is not negligible
  function automatic logic signed [31:0] near(logic signed [31:0] c, logic [30:0] rad);
    longint span;
    span = longint'(rad) * $urandom_range(1, 5);
    if (span > 64'sh7FFFFFFF) span = 64'sh7FFFFFFF;
    return c + 32'($signed(longint'($urandom_range(0, 32'(span))) * 2 - span) / 2);
  endfunction

  function automatic logic [30:0] pick_radius();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 31'd0;
    if (p == 1) return 31'h7FFF_FFFF;
    if (p < 5) return 31'($urandom());
    return 31'($urandom_range(1, 1 << $urandom_range(4, 26)));
  endfunction

  // one own particle against a few sources, last one marked
  task automatic send_group();
    in_req_t it;
    int n;
    n = $urandom_range(1, 6);
    it.own_x = $urandom(); it.own_y = $urandom(); it.own_z = $urandom();
    it.own_radius = pick_radius();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        it.source_x = $urandom(); it.source_y = $urandom(); it.source_z = $urandom();
      end else begin
        it.source_x = near(it.own_x, it.own_radius);
        it.source_y = near(it.own_y, it.own_radius);
        it.source_z = near(it.own_z, it.own_radius);
      end
      // a broken group now and then: last marked early or a fully random item
      if ($urandom_range(0, 19) == 0) it = in_req_t'({$urandom(), $urandom(), $urandom(),
        $urandom(), $urandom(), $urandom(), $urandom()});
      it.last_source = (i == n - 1) || ($urandom_range(0, 15) == 0);
      send_request(it);
    end
  endtask

  initial begin
    logic [31:0] factors[6];
    logic [31:0] gains[6];
    factors = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000,
                32'h0000_0001, 32'h0003_8000};
    gains   = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_8000,
                32'h4000_0000, 32'h0002_0000};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings first
    // extremes of position with the largest radius, a pair inside the far cut
    send_request(pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                      32'h80000000, 32'h80000000, 32'h80000000, 1'b1));
    // coincident particles, r is zero
    send_request(pair(32'h12345678, -32'sd5, 32'sd7, 31'h10000, 32'h12345678, -32'sd5,
                      32'sd7, 1'b1));
    // zero radius
    send_request(pair(0, 0, 0, 31'd0, 32'sd1000, 0, 0, 1'b1));
    // near pair, then two at about 5.5 radii, inside the far cut; only the third is last
    send_request(pair(32'h00010000, 0, 0, 31'h10000, 0, 0, 0, 1'b0));
    send_request(pair(0, 32'h00058000, 0, 31'h10000, 0, 0, 0, 1'b0));
    send_request(pair(0, 0, 32'sh00057F00, 31'h10000, 0, 0, 0, 1'b1));
    // smallest radius
    send_request(pair(32'sd1, 32'sd0, -32'sd1, 31'd1, 0, 0, 0, 1'b1));
    drain();

    // large gain and factor with huge r: sums and outputs saturate
    write_reg(CFG_FORCE_FACTOR, 32'h7FFF_FFFF);
    write_reg(CFG_ENERGY_GAIN, 32'h7FFF_FFFF);
    for (int i = 0; i < 4; i++)
      send_request(pair(32'h7FFF0000, 32'h80010000, 32'h40000000, 31'h7FFFFFFF,
                        32'h80000000, 32'h7FFFFFFF, 32'hC0000000, i == 3));
    send_request(pair(32'h80000000, 32'h7FFFFFFF, 0, 31'h40000000, 32'h40000000,
                      32'h80000000, 32'h7FFFFFFF, 1'b1));
    drain();
    write_reg(CFG_FORCE_FACTOR, 32'h8000_0000);
    send_request(pair(32'h40000000, 32'hC0000000, 32'h20000000, 31'h30000000,
                      32'hC0000000, 32'h40000000, 32'hE0000000, 1'b1));
    drain();

    // random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_FORCE_FACTOR, factors[ph]);
      write_reg(CFG_ENERGY_GAIN, gains[ph]);
      while (sent < 20 + (ph + 1) * (N_RANDOM / 6)) send_group();
      drain();
    end

    $display("sent %0d requests over six register settings, %0d increments checked",
             sent, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("gaussian_repulsion_accumulate_top regression: pass");
    end else begin
      $display("gaussian_repulsion_accumulate_top regression: fail");
    end
    $finish;
  end
endmodule
